>>> src/mpq_pkg.sv
// Package for the max priority queue: transaction structs and status codes.
// No dependencies.
package mpq_pkg;

   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic               func;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic signed [31:0] max_key;
      logic [1:0]         status;
      logic [6:0]         entry_count;
      logic [2:0]         tree_height;
   } rsp_type;

endpackage

>>> src/max_priority_queue_unit.sv
// Max priority queue: a 32-bit key memory with a sequential scan for the largest key.
// Depends on mpq_pkg.
//
// An insert passes through S_INS and S_DONE before its rsp_valid strobe. An extract
// scans the n stored keys in the one-read-port key memory one entry per cycle in S_SCAN,
// then S_LAST, S_MOVE and S_DONE. busy is high from the accepting edge until the response strobe.
// The response is on the rsp_ ports for exactly one cycle and the receiver cannot stall it.
module max_priority_queue_unit #(
   parameter int DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  mpq_pkg::req_type req_data,
   output logic            rsp_valid,
   output mpq_pkg::rsp_type rsp_data
);
   import mpq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_INS, S_SCAN, S_LAST, S_MOVE, S_DONE
   } state_type;

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_ff;

   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   logic [AW-1:0]      best_ff;
   logic signed [31:0] best_key_ff;
   logic               first_ff;
   req_type            req_ff;
   logic               busy_ff, valid_ff;
   rsp_type            rsp_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic signed [31:0] wr_data;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      last_idx;

   assign last_idx = count_ff - CW'(1);
   assign count_in = (count_ff < CW'(DEPTH)) ? count_ff + CW'(1) : count_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_ff;
      wr_data = rd_ff;
      rd_addr = idx_ff[AW-1:0];
      if (state_ff == S_INS) begin
         wr_en   = (count_ff < CW'(DEPTH));
         wr_addr = count_ff[AW-1:0];
         wr_data = req_ff.key;
      end else if (state_ff == S_MOVE) begin
         wr_en = 1'b1;
      end
      // entry 0 is fetched at the accepting edge so the scan starts on it
      if (state_ff == S_IDLE) rd_addr = '0;
      if (state_ff == S_LAST) rd_addr = last_idx[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   function automatic logic [2:0] bit_len(input logic [CW-1:0] v);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < CW; i++)
         if (v[i]) n = 3'(i + 1);
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  busy_ff  <= 1'b1;
                  idx_ff   <= '0;
                  first_ff <= 1'b1;
                  if (req_data.func == FUNC_INSERT) begin
                     state_ff <= S_INS;
                  end else if (count_ff == '0) begin
                     rsp_ff <= '{max_key: '0, status: STATUS_EMPTY,
                                 entry_count: 7'(count_ff), tree_height: 3'd0};
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff   <= CW'(1);
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_INS: begin
               count_ff <= count_in;
               rsp_ff <= '{max_key: '0,
                           status: (count_ff < CW'(DEPTH)) ? STATUS_OK : STATUS_FULL,
                           entry_count: 7'(count_in), tree_height: bit_len(count_in)};
               state_ff <= S_DONE;
            end
            S_SCAN: begin
               // rd_ff holds entry idx_ff-1
               first_ff <= 1'b0;
               if (first_ff || rd_ff > best_key_ff) begin
                  best_key_ff <= rd_ff;
                  best_ff     <= AW'(idx_ff - CW'(1));
               end
               if (idx_ff == count_ff) state_ff <= S_LAST;
               else idx_ff <= idx_ff + CW'(1);
            end
            S_LAST: begin
               state_ff <= S_MOVE;  // last entry being read
            end
            S_MOVE: begin
               count_ff <= last_idx;
               rsp_ff <= '{max_key: best_key_ff, status: STATUS_OK,
                           entry_count: 7'(last_idx), tree_height: bit_len(last_idx)};
               state_ff <= S_DONE;
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               busy_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/mpq_checker.sv
// Port-level checks for the max priority queue, bound to the top level.
// Depends on mpq_pkg.
module mpq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mpq_pkg::req_type req_data,
   input logic             rsp_valid,
   input mpq_pkg::rsp_type rsp_data
);
   import mpq_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy after response");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= STATUS_FULL) else $error("bad status");
   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.max_key == 0
         && rsp_data.entry_count == 0) else $error("empty extract");

endmodule

bind max_priority_queue_unit mpq_checker u_mpq_checker (.*);

>>> test/tb_max_priority_queue_unit.sv
// Testbench for max_priority_queue_unit: directed and random insert/extract traffic checked
// against a behavioural model of the key store. Depends on mpq_pkg.
`timescale 1ns / 1ps

module tb_max_priority_queue_unit;
   import mpq_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      req_type req;
      int      idle_pct;
   } pending_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   pending_item_type pending_items[$];
   rsp_type          expected_rsps[$];
   logic signed [31:0] held_keys[STORE_DEPTH];
   int               held_count = 0;
   int               items_total = 0;
   int               items_accepted = 0;
   int               error_count = 0;
   int               cycle_count = 0;

   max_priority_queue_unit #(.DEPTH(STORE_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one transaction to the model store and returns the expected response.
   function rsp_type queue_apply(req_type r);
      rsp_type res;
      int      best;
      int      n;
      res = '0;
      res.status = STATUS_OK;
      if (r.func == FUNC_INSERT) begin
         if (held_count >= STORE_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            held_keys[held_count] = r.key;
            held_count++;
         end
      end else if (held_count == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         best = 0;
         for (int i = 1; i < held_count; i++)
            if (held_keys[i] > held_keys[best]) best = i;
         res.max_key = held_keys[best];
         held_count--;
         held_keys[best] = held_keys[held_count];
      end
      res.entry_count = held_count[6:0];
      n = 0;
      for (int v = held_count; v != 0; v = v >> 1) n++;
      res.tree_height = n[2:0];
      return res;
   endfunction

   task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR: %s got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            expected_rsps = {expected_rsps, queue_apply(req_data)};
            items_accepted++;
         end
         if (!start || !busy) begin
            if (pending_items.size() > 0 &&
                $urandom_range(99, 0) >= pending_items[0].idle_pct) begin
               start <= 1'b1;
               req_data <= pending_items[0].req;
               void'(pending_items.pop_front());
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.max_key, 32'h0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.max_key !== want.max_key)
               report_mismatch("max_key", rsp_data.max_key, want.max_key);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch("entry_count", 32'(rsp_data.entry_count),
                               32'(want.entry_count));
            if (rsp_data.tree_height !== want.tree_height)
               report_mismatch("tree_height", 32'(rsp_data.tree_height),
                               32'(want.tree_height));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", expected_rsps.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task add_item(logic func, logic signed [31:0] key, int idle_pct);
      pending_item_type it;
      it.req.func = func;
      it.req.key = key;
      it.idle_pct = idle_pct;
      pending_items = {pending_items, it};
      items_total++;
   endtask

   function logic signed [31:0] random_key();
      case ($urandom_range(3, 0))
         0: return $signed($urandom_range(4, 0)) - 2;
         1: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int idle_by_phase[4] = '{0, 84, 0, 12};
      int burst;
      // directed: empty extract, extremes, duplicate maxima, drain to empty
      add_item(FUNC_EXTRACT, 32'sh7fffffff, 0);
      add_item(FUNC_INSERT, 32'sh80000000, 0);
      add_item(FUNC_INSERT, 32'sh7fffffff, 0);
      add_item(FUNC_INSERT, 32'sh0, 0);
      add_item(FUNC_INSERT, -32'sd1, 0);
      add_item(FUNC_INSERT, 32'sh7fffffff, 0);
      add_item(FUNC_INSERT, 32'sd5, 0);
      add_item(FUNC_INSERT, 32'sd5, 0);
      for (int i = 0; i < 8; i++) add_item(FUNC_EXTRACT, 32'sh5a5a5a5a, 0);
      add_item(FUNC_INSERT, 32'sh80000000, 0);
      add_item(FUNC_EXTRACT, 32'sh0, 0);
      add_item(FUNC_EXTRACT, 32'sh0, 0);

      // random: insert and extract bursts so the store swings between empty and full
      for (int p = 0; p < 4; p++) begin
         int phase_end;
         phase_end = items_total + 185;
         while (items_total < phase_end) begin
            burst = $urandom_range(80, 1);
            for (int i = 0; i < burst && items_total < phase_end; i++)
               add_item($urandom_range(9, 0) == 0, random_key(), idle_by_phase[p]);
            burst = $urandom_range(80, 1);
            for (int i = 0; i < burst && items_total < phase_end; i++)
               add_item($urandom_range(9, 0) != 0, random_key(), idle_by_phase[p]);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (items_accepted < items_total || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
